/* rtl/core/pvs_pkg.sv */
// ============================================================================
// pvs_pkg: shared types and constants of the velocity servo axis
// Holds number formats, register indexes, sequencer states and the
// saturation helpers that the datapath and the arithmetic units share.
// ============================================================================
package pvs_pkg;

    localparam int VALUE_WIDTH        = 32;
    localparam int TIME_FRACTION_BITS = 20;
    localparam int FRAC_BITS          = 16;
    localparam int PROD_WIDTH         = 2 * VALUE_WIDTH;
    localparam int WIDE_WIDTH         = VALUE_WIDTH + 2;
    localparam int DIVIDEND_WIDTH     = VALUE_WIDTH + TIME_FRACTION_BITS;
    localparam int DIV_COUNT_WIDTH    = $clog2(DIVIDEND_WIDTH + 1);
    localparam int CFG_INDEX_WIDTH    = 3;
    localparam int LIMIT_WIDTH        = VALUE_WIDTH - 1;

    // Smallest interval (in time units) of at least 100 us.
    localparam int DERIV_MIN_DT = (2 ** TIME_FRACTION_BITS + 9999) / 10000;

    typedef logic signed [VALUE_WIDTH-1:0] value_t;
    typedef logic signed [WIDE_WIDTH-1:0]  wide_t;
    typedef logic [TIME_FRACTION_BITS-1:0] dt_t;
    typedef logic [PROD_WIDTH-1:0]         prod_t;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_SERVO_GAIN        = 3'd0,
        REG_INTEGRAL_FACTOR   = 3'd1,
        REG_FEEDFORWARD_SCALE = 3'd2,
        REG_DERIVATIVE_TIME   = 3'd3,
        REG_FRICTION_OFFSET   = 3'd4,
        REG_DRIVE_LIMIT       = 3'd5,
        REG_LOWER_LIMIT       = 3'd6,
        REG_UPPER_LIMIT       = 3'd7
    } cfg_reg_t;

    typedef enum logic {
        SHIFT_FRAC,
        SHIFT_TIME
    } mul_shift_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_MUL_REF,
        ST_ADD_REF,
        ST_ERR,
        ST_MUL_INT,
        ST_ADD_INT,
        ST_MUL_DERIV,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_MUL_INTEG,
        ST_SUM,
        ST_MUL_GAIN,
        ST_GAIN_TERM,
        ST_VEL,
        ST_FRICTION
    } state_t;

    // Request to the iterative time divider.
    typedef struct packed {
        logic                   start;
        logic                   neg;
        logic [VALUE_WIDTH-1:0] magnitude;
        dt_t                    divisor;
    } div_req_t;

    // Saturate a wide signed sum to the value range.
    function automatic value_t sat_wide(input wide_t v);
        wide_t vmax;
        wide_t vmin;
        begin
            vmax = WIDE_WIDTH'((64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1);
            vmin = -vmax - WIDE_WIDTH'(1);
            if (v > vmax)
                sat_wide = VALUE_WIDTH'(vmax);
            else if (v < vmin)
                sat_wide = VALUE_WIDTH'(vmin);
            else
                sat_wide = VALUE_WIDTH'(v);
        end
    endfunction

    // Turn a magnitude and sign into a saturated signed value.
    function automatic value_t from_mag(input prod_t m, input logic neg);
        prod_t lim;
        begin
            lim = prod_t'(1) << (VALUE_WIDTH - 1);
            if (neg)
                from_mag = (m > lim) ? value_t'(lim[VALUE_WIDTH-1:0])
                                     : -value_t'(m[VALUE_WIDTH-1:0]);
            else
                from_mag = (m > lim - prod_t'(1)) ? value_t'(lim[VALUE_WIDTH-1:0] - 1'b1)
                                                  : value_t'(m[VALUE_WIDTH-1:0]);
        end
    endfunction

    // Absolute value as an unsigned word (the most negative value fits).
    function automatic logic [VALUE_WIDTH-1:0] magnitude(input value_t v);
        begin
            magnitude = v[VALUE_WIDTH-1] ? (~v + 1'b1) : v;
        end
    endfunction

endpackage

/* rtl/core/pid_velocity_servo_axis.sv */
// ============================================================================
// pid_velocity_servo_axis: single-axis velocity servo with PI-D correction
// Position reference, error integral, derivative, feedforward, friction
// offset, drive clamp and position range flag, on one shared multiplier.
// ============================================================================
// Usage: one instance per axis. Samples arrive on the in_* channel
// (valid/ready); each accepted transaction yields exactly one result
// transaction on the out_* channel. operation 1 loads the position and
// marks the axis homed; operation 0 is a control sample.
// Configuration registers are written through cfg_valid/cfg_index/cfg_data
// (cfg_ready is always high). The user must write them only while no sample
// is in flight; the block itself does not enforce this.
// A load or an undriven sample goes from the start state straight to the
// friction step and the output register. A driven sample steps through the
// shared multiplier, plus the one-bit-per-cycle time divider (52 quotient
// bits) when the derivative runs. The first sample runs with a zero
// interval and never uses the divider.
// One sample is processed at a time; in_ready is high only when the
// sequencer is idle. The result waits in an output register while the
// receiver stalls; the next sample is accepted meanwhile and finishes up
// to its last step, where it holds until the output register frees.
// Reset clears the servo state and loads the configuration defaults.
// ============================================================================
module pid_velocity_servo_axis
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  operation,
    input  logic signed [pvs_pkg::VALUE_WIDTH-1:0] measured_position,
    input  logic signed [pvs_pkg::VALUE_WIDTH-1:0] velocity_setpoint,
    input  logic [pvs_pkg::TIME_FRACTION_BITS-1:0] elapsed_time,
    input  logic                                  axis_driven,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [pvs_pkg::VALUE_WIDTH-1:0] drive_velocity,
    output logic                                  position_out_of_range,
    output logic                                  drive_saturated,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [pvs_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [pvs_pkg::VALUE_WIDTH-1:0]       cfg_data
);

    localparam int VW = pvs_pkg::VALUE_WIDTH;
    localparam int WW = pvs_pkg::WIDE_WIDTH;
    localparam int LW = pvs_pkg::LIMIT_WIDTH;

    pvs_pkg::state_t state_reg, state_next;

    // Configuration registers.
    pvs_pkg::value_t gain_reg, ifac_reg, ffwd_reg, dtime_reg, fric_reg;
    pvs_pkg::value_t lower_reg, upper_reg;
    logic [LW-1:0]   limit_reg;

    // Servo state.
    pvs_pkg::value_t ref_reg,   ref_next;
    pvs_pkg::value_t integ_reg, integ_next;
    pvs_pkg::value_t last_reg,  last_next;
    logic            started_reg, started_next;
    logic            homed_reg,   homed_next;

    // Sample and working registers.
    logic            op_reg;
    logic            driven_reg;
    pvs_pkg::value_t meas_reg, setp_reg;
    pvs_pkg::dt_t    dt_reg,    dt_next;
    pvs_pkg::value_t err_reg,   err_next;
    pvs_pkg::value_t deriv_reg, deriv_next;
    pvs_pkg::value_t sum_reg,   sum_next;
    pvs_pkg::value_t gterm_reg, gterm_next;
    pvs_pkg::value_t vel_reg,   vel_next;
    logic            oor_reg,   oor_next;

    // Output register.
    logic            out_valid_reg, out_valid_next;
    pvs_pkg::value_t out_vel_reg,   out_vel_next;
    logic            out_oor_reg,   out_oor_next;
    logic            out_sat_reg,   out_sat_next;

    // Shared units.
    pvs_pkg::value_t     mul_a, mul_b, mul_res;
    pvs_pkg::mul_shift_t mul_shift;
    pvs_pkg::div_req_t   div_req;
    logic                div_done;
    pvs_pkg::value_t     div_res;

    logic            in_fire;
    pvs_pkg::value_t pos_diff;
    pvs_pkg::value_t fric_sum;
    pvs_pkg::wide_t  lim_wide;
    pvs_pkg::wide_t  vel_wide;

    assign in_ready  = (state_reg == pvs_pkg::ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    pvs_mul u_mul
    (
        .clk       (clk),
        .op_a      (mul_a),
        .op_b      (mul_b),
        .shift_sel (mul_shift),
        .result    (mul_res)
    );

    pvs_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_res)
    );

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg  <= '0;
            ifac_reg  <= '0;
            ffwd_reg  <= '0;
            dtime_reg <= '0;
            fric_reg  <= '0;
            limit_reg <= '1;
            lower_reg <= {1'b1, {(VW-1){1'b0}}};
            upper_reg <= {1'b0, {(VW-1){1'b1}}};
        end
        else if (cfg_valid)
        begin
            unique case (pvs_pkg::cfg_reg_t'(cfg_index))
                pvs_pkg::REG_SERVO_GAIN:        gain_reg  <= cfg_data;
                pvs_pkg::REG_INTEGRAL_FACTOR:   ifac_reg  <= cfg_data;
                pvs_pkg::REG_FEEDFORWARD_SCALE: ffwd_reg  <= cfg_data;
                pvs_pkg::REG_DERIVATIVE_TIME:   dtime_reg <= cfg_data;
                pvs_pkg::REG_FRICTION_OFFSET:   fric_reg  <= cfg_data;
                pvs_pkg::REG_DRIVE_LIMIT:       limit_reg <= cfg_data[LW-1:0];
                pvs_pkg::REG_LOWER_LIMIT:       lower_reg <= cfg_data;
                pvs_pkg::REG_UPPER_LIMIT:       upper_reg <= cfg_data;
                default:                        gain_reg  <= gain_reg;
            endcase
        end
    end

    // Control and servo state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pvs_pkg::ST_IDLE;
            ref_reg       <= '0;
            integ_reg     <= '0;
            last_reg      <= '0;
            started_reg   <= 1'b0;
            homed_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ref_reg       <= ref_next;
            integ_reg     <= integ_next;
            last_reg      <= last_next;
            started_reg   <= started_next;
            homed_reg     <= homed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg     <= operation;
            driven_reg <= axis_driven;
            meas_reg   <= measured_position;
            setp_reg   <= velocity_setpoint;
        end
        dt_reg      <= in_fire ? elapsed_time : dt_next;
        err_reg     <= err_next;
        deriv_reg   <= deriv_next;
        sum_reg     <= sum_next;
        gterm_reg   <= gterm_next;
        vel_reg     <= vel_next;
        oor_reg     <= oor_next;
        out_vel_reg <= out_vel_next;
        out_oor_reg <= out_oor_next;
        out_sat_reg <= out_sat_next;
    end

    // Helpers for the difference, friction and clamp steps.
    always_comb
    begin
        pos_diff = pvs_pkg::sat_wide(WW'(meas_reg) - WW'(last_reg));
        if (last_reg < meas_reg)
            fric_sum = pvs_pkg::sat_wide(WW'(vel_reg) + WW'(fric_reg));
        else if (last_reg > meas_reg)
            fric_sum = pvs_pkg::sat_wide(WW'(vel_reg) - WW'(fric_reg));
        else if (vel_reg < 0)
            fric_sum = pvs_pkg::sat_wide(WW'(vel_reg) - WW'(fric_reg));
        else
            fric_sum = pvs_pkg::sat_wide(WW'(vel_reg) + WW'(fric_reg));
        lim_wide = pvs_pkg::wide_t'({1'b0, limit_reg});
        vel_wide = WW'(fric_sum);
    end

    // Sequencer: next state, datapath updates and shared unit operands.
    always_comb
    begin
        state_next     = state_reg;
        ref_next       = ref_reg;
        integ_next     = integ_reg;
        last_next      = last_reg;
        started_next   = started_reg;
        homed_next     = homed_reg;
        dt_next        = dt_reg;
        err_next       = err_reg;
        deriv_next     = deriv_reg;
        sum_next       = sum_reg;
        gterm_next     = gterm_reg;
        vel_next       = vel_reg;
        oor_next       = oor_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_vel_next   = out_vel_reg;
        out_oor_next   = out_oor_reg;
        out_sat_next   = out_sat_reg;
        mul_a          = pvs_pkg::value_t'({{(VW-pvs_pkg::TIME_FRACTION_BITS){1'b0}}, dt_reg});
        mul_b          = setp_reg;
        mul_shift      = pvs_pkg::SHIFT_TIME;
        div_req        = '0;

        unique case (state_reg)
            pvs_pkg::ST_IDLE:
            begin
                if (in_fire)
                    state_next = pvs_pkg::ST_START;
            end

            // Range check, load operation and first sample setup.
            pvs_pkg::ST_START:
            begin
                oor_next   = homed_reg && (meas_reg < lower_reg || meas_reg > upper_reg);
                vel_next   = '0;
                deriv_next = '0;
                if (op_reg)
                begin
                    ref_next   = meas_reg;
                    last_next  = meas_reg;
                    homed_next = 1'b1;
                    oor_next   = 1'b0;
                    state_next = pvs_pkg::ST_FRICTION;
                end
                else
                begin
                    if (!started_reg)
                    begin
                        dt_next      = '0;
                        ref_next     = meas_reg;
                        last_next    = meas_reg;
                        started_next = 1'b1;
                    end
                    state_next = driven_reg ? pvs_pkg::ST_MUL_REF : pvs_pkg::ST_FRICTION;
                end
            end

            pvs_pkg::ST_MUL_REF:
            begin
                state_next = pvs_pkg::ST_ADD_REF;
            end

            pvs_pkg::ST_ADD_REF:
            begin
                ref_next   = pvs_pkg::sat_wide(WW'(ref_reg) + WW'(mul_res));
                state_next = pvs_pkg::ST_ERR;
            end

            pvs_pkg::ST_ERR:
            begin
                err_next   = pvs_pkg::sat_wide(WW'(ref_reg) - WW'(meas_reg));
                state_next = pvs_pkg::ST_MUL_INT;
            end

            pvs_pkg::ST_MUL_INT:
            begin
                mul_b      = err_reg;
                state_next = pvs_pkg::ST_ADD_INT;
            end

            pvs_pkg::ST_ADD_INT:
            begin
                integ_next = pvs_pkg::sat_wide(WW'(integ_reg) + WW'(mul_res));
                state_next = pvs_pkg::ST_MUL_DERIV;
            end

            pvs_pkg::ST_MUL_DERIV:
            begin
                mul_a      = dtime_reg;
                mul_b      = pos_diff;
                mul_shift  = pvs_pkg::SHIFT_FRAC;
                state_next = pvs_pkg::ST_DIV_START;
            end

            // Derivative only for intervals of at least 100 us.
            pvs_pkg::ST_DIV_START:
            begin
                if (dt_reg >= pvs_pkg::dt_t'(pvs_pkg::DERIV_MIN_DT))
                begin
                    div_req.start     = 1'b1;
                    div_req.neg       = mul_res[VW-1];
                    div_req.magnitude = pvs_pkg::magnitude(mul_res);
                    div_req.divisor   = dt_reg;
                    state_next        = pvs_pkg::ST_DIV_WAIT;
                end
                else
                begin
                    state_next = pvs_pkg::ST_MUL_INTEG;
                end
            end

            pvs_pkg::ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    deriv_next = div_res;
                    state_next = pvs_pkg::ST_MUL_INTEG;
                end
            end

            pvs_pkg::ST_MUL_INTEG:
            begin
                mul_a      = ifac_reg;
                mul_b      = integ_reg;
                mul_shift  = pvs_pkg::SHIFT_FRAC;
                state_next = pvs_pkg::ST_SUM;
            end

            pvs_pkg::ST_SUM:
            begin
                sum_next   = pvs_pkg::sat_wide(WW'(err_reg) + WW'(mul_res) + WW'(deriv_reg));
                state_next = pvs_pkg::ST_MUL_GAIN;
            end

            pvs_pkg::ST_MUL_GAIN:
            begin
                mul_a      = gain_reg;
                mul_b      = sum_reg;
                mul_shift  = pvs_pkg::SHIFT_FRAC;
                state_next = pvs_pkg::ST_GAIN_TERM;
            end

            // Capture the gain term and start the feedforward product.
            pvs_pkg::ST_GAIN_TERM:
            begin
                gterm_next = mul_res;
                mul_a      = ffwd_reg;
                mul_b      = setp_reg;
                mul_shift  = pvs_pkg::SHIFT_FRAC;
                state_next = pvs_pkg::ST_VEL;
            end

            pvs_pkg::ST_VEL:
            begin
                vel_next   = pvs_pkg::sat_wide(WW'(gterm_reg) + WW'(mul_res));
                state_next = pvs_pkg::ST_FRICTION;
            end

            // Friction offset, clamp and hand-off to the output register.
            default:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_oor_next   = oor_reg;
                    out_sat_next   = 1'b0;
                    out_vel_next   = '0;
                    if (!op_reg)
                        last_next = meas_reg;
                    if (!op_reg && driven_reg)
                    begin
                        if (vel_wide < -lim_wide)
                        begin
                            out_vel_next = VW'(-lim_wide);
                            out_sat_next = 1'b1;
                        end
                        else if (vel_wide > lim_wide)
                        begin
                            out_vel_next = VW'(lim_wide);
                            out_sat_next = 1'b1;
                        end
                        else
                        begin
                            out_vel_next = fric_sum;
                        end
                    end
                    state_next = pvs_pkg::ST_IDLE;
                end
            end
        endcase
    end

    assign out_valid             = out_valid_reg;
    assign drive_velocity        = out_vel_reg;
    assign position_out_of_range = out_oor_reg;
    assign drive_saturated       = out_sat_reg;

endmodule

/* rtl/core/pvs_mul.sv */
// ============================================================================
// pvs_mul: shared sign-magnitude multiplier
// Multiplies two values, registers the product, then shifts it right by
// the selected fraction width with truncation toward zero and saturation.
// ============================================================================
module pvs_mul
(
    input  logic                clk,
    input  pvs_pkg::value_t     op_a,
    input  pvs_pkg::value_t     op_b,
    input  pvs_pkg::mul_shift_t shift_sel,
    output pvs_pkg::value_t     result
);

    pvs_pkg::prod_t      prod_reg;
    logic                neg_reg;
    pvs_pkg::mul_shift_t shift_reg;
    pvs_pkg::prod_t      shifted;

    // Product register between the multiplier and the shifter.
    always_ff @(posedge clk)
    begin
        prod_reg  <= pvs_pkg::prod_t'(pvs_pkg::magnitude(op_a))
                   * pvs_pkg::prod_t'(pvs_pkg::magnitude(op_b));
        neg_reg   <= op_a[pvs_pkg::VALUE_WIDTH-1] ^ op_b[pvs_pkg::VALUE_WIDTH-1];
        shift_reg <= shift_sel;
    end

    // Rescale and saturate.
    always_comb
    begin
        unique case (shift_reg)
            pvs_pkg::SHIFT_TIME: shifted = prod_reg >> pvs_pkg::TIME_FRACTION_BITS;
            default:             shifted = prod_reg >> pvs_pkg::FRAC_BITS;
        endcase
        result = pvs_pkg::from_mag(shifted, neg_reg);
    end

endmodule

/* rtl/core/pvs_div.sv */
// ============================================================================
// pvs_div: iterative time divider
// Computes (magnitude << TIME_FRACTION_BITS) / divisor one quotient bit
// per cycle with a restoring step, then signs and saturates the result.
// ============================================================================
module pvs_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  pvs_pkg::div_req_t req,
    output logic              done,
    output pvs_pkg::value_t   quotient
);

    localparam int DW = pvs_pkg::DIVIDEND_WIDTH;
    localparam int VW = pvs_pkg::VALUE_WIDTH;
    localparam int TW = pvs_pkg::TIME_FRACTION_BITS;
    localparam int CW = pvs_pkg::DIV_COUNT_WIDTH;

    logic                  busy_reg,    busy_next;
    logic                  done_reg,    done_next;
    logic [CW-1:0]         count_reg,   count_next;
    logic [DW-1:0]         dividend_reg, dividend_next;
    logic [TW-1:0]         rem_reg,     rem_next;
    logic [VW:0]           quot_reg,    quot_next;
    logic                  ovf_reg,     ovf_next;
    logic                  neg_reg,     neg_next;
    pvs_pkg::dt_t          divisor_reg, divisor_next;
    logic [TW:0]           trial;
    logic                  fits;

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        dividend_reg <= dividend_next;
        rem_reg      <= rem_next;
        quot_reg     <= quot_next;
        ovf_reg      <= ovf_next;
        neg_reg      <= neg_next;
        divisor_reg  <= divisor_next;
    end

    // One restoring step per cycle.
    always_comb
    begin
        busy_next     = busy_reg;
        done_next     = 1'b0;
        count_next    = count_reg;
        dividend_next = dividend_reg;
        rem_next      = rem_reg;
        quot_next     = quot_reg;
        ovf_next      = ovf_reg;
        neg_next      = neg_reg;
        divisor_next  = divisor_reg;
        trial         = {rem_reg, dividend_reg[DW-1]};
        fits          = trial >= {1'b0, divisor_reg};
        if (req.start)
        begin
            busy_next     = 1'b1;
            count_next    = CW'(DW);
            dividend_next = {req.magnitude, TW'(0)};
            rem_next      = '0;
            quot_next     = '0;
            ovf_next      = 1'b0;
            neg_next      = req.neg;
            divisor_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            dividend_next = dividend_reg << 1;
            rem_next      = fits ? TW'(trial - {1'b0, divisor_reg}) : trial[TW-1:0];
            quot_next     = {quot_reg[VW-1:0], fits};
            ovf_next      = ovf_reg | quot_reg[VW];
            count_next    = count_reg - 1'b1;
            if (count_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done     = done_reg;
    assign quotient = pvs_pkg::from_mag(ovf_reg ? '1 : pvs_pkg::prod_t'(quot_reg), neg_reg);

endmodule

/* rtl/core/pvs_checker.sv */
// ============================================================================
// pvs_checker: port-level checks for the velocity servo axis
// Watches the handshakes and result fields of the top level.
// ============================================================================
module pvs_checker
(
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  in_valid,
    input logic                                  in_ready,
    input logic                                  out_valid,
    input logic                                  out_ready,
    input logic signed [pvs_pkg::VALUE_WIDTH-1:0] drive_velocity,
    input logic                                  drive_saturated,
    input logic                                  cfg_ready
);

    // A stalled result transaction holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(drive_velocity))
        else $error("result changed while stalled");

    // One sample at a time: after an input transaction the block is busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while busy");

    // A clamped command never reaches the most negative value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && drive_saturated |->
            drive_velocity != {1'b1, {(pvs_pkg::VALUE_WIDTH-1){1'b0}}})
        else $error("clamped command beyond the drive limit");

    // Configuration is always taken.
    assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("configuration port stalled");

endmodule

bind pid_velocity_servo_axis pvs_checker u_pvs_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .drive_velocity  (drive_velocity),
    .drive_saturated (drive_saturated),
    .cfg_ready       (cfg_ready)
);

/* verif/testbench.sv */
// ============================================================================
// testbench: self-checking bench for the velocity servo axis
// A table of directed samples runs first. Random phases follow, each with its
// own register settings. A behavioral predictor computes every result, and
// each result transaction is compared with the oldest pending prediction.
// ============================================================================
`timescale 1ns / 1ps

module testbench;

    localparam longint VMAX_L = 64'sd2147483647;
    localparam longint VMIN_L = -64'sd2147483648;
    localparam int     RANDOM_PHASES = 12;
    localparam int     ITEMS_PER_PHASE = 125;
    localparam int     LONG_HOLD_CYCLES = 600;
    localparam int     IDLE_LIMIT = 5000;
    localparam int     DRAIN_CYCLES = 200;

    // One servo command as the block returns it
    typedef struct {
        logic signed [31:0] velocity;
        logic               out_of_range;
        logic               saturated;
    } servo_cmd_t;

    // One row of the directed table
    typedef struct {
        logic        op;
        logic [31:0] pos;
        logic [31:0] setp;
        logic [19:0] dt;
        logic        drv;
        logic        typed;
        logic [31:0] t_vel;
        logic        t_oor;
        logic        t_sat;
    } sample_row_t;

    logic                                   clk;
    logic                                   rst_n;
    logic                                   in_valid;
    logic                                   in_ready;
    logic                                   operation;
    logic signed [pvs_pkg::VALUE_WIDTH-1:0] measured_position;
    logic signed [pvs_pkg::VALUE_WIDTH-1:0] velocity_setpoint;
    logic [pvs_pkg::TIME_FRACTION_BITS-1:0] elapsed_time;
    logic                                   axis_driven;
    logic                                   out_valid;
    logic                                   out_ready;
    logic signed [pvs_pkg::VALUE_WIDTH-1:0] drive_velocity;
    logic                                   position_out_of_range;
    logic                                   drive_saturated;
    logic                                   cfg_valid;
    logic                                   cfg_ready;
    pvs_pkg::cfg_reg_t                      cfg_index;
    logic [pvs_pkg::VALUE_WIDTH-1:0]        cfg_data;

    // Mirror of the block's registers and servo state
    longint     gain_regs[8];
    longint     ref_pos;
    longint     err_integral;
    longint     prev_pos;
    bit         sampling_on;
    bit         homed;

    servo_cmd_t pending_cmds[$];
    int         mismatches;
    int         idle_cycles;
    bit         long_hold_req;
    bit         rx_free_run;
    logic [31:0] walk_pos;

    pid_velocity_servo_axis uut
    (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .in_valid              (in_valid),
        .in_ready              (in_ready),
        .operation             (operation),
        .measured_position     (measured_position),
        .velocity_setpoint     (velocity_setpoint),
        .elapsed_time          (elapsed_time),
        .axis_driven           (axis_driven),
        .out_valid             (out_valid),
        .out_ready             (out_ready),
        .drive_velocity        (drive_velocity),
        .position_out_of_range (position_out_of_range),
        .drive_saturated       (drive_saturated),
        .cfg_valid             (cfg_valid),
        .cfg_ready             (cfg_ready),
        .cfg_index             (cfg_index),
        .cfg_data              (cfg_data)
    );

    // Directed samples: extremes, load, undriven, derivative threshold
    sample_row_t sample_table[15] = '{
        '{1'b0, 32'h00010000, 32'h00000000, 20'h01000, 1'b1, 1'b1, 32'h00008000, 1'b0, 1'b0},
        '{1'b0, 32'h00020000, 32'h00010000, 20'd104,   1'b1, 1'b0, 32'h0, 1'b0, 1'b0},
        '{1'b0, 32'h00020000, 32'h00010000, 20'd105,   1'b1, 1'b0, 32'h0, 1'b0, 1'b0},
        '{1'b0, 32'h00018000, 32'hffff0000, 20'hfffff, 1'b1, 1'b0, 32'h0, 1'b0, 1'b0},
        '{1'b0, 32'h7fffffff, 32'h7fffffff, 20'h00400, 1'b1, 1'b0, 32'h0, 1'b0, 1'b0},
        '{1'b0, 32'h80000000, 32'h80000000, 20'h00400, 1'b1, 1'b0, 32'h0, 1'b0, 1'b0},
        '{1'b0, 32'h00000000, 32'h00000000, 20'h00000, 1'b0, 1'b1, 32'h0, 1'b0, 1'b0},
        '{1'b1, 32'h00640001, 32'h00000000, 20'h00000, 1'b0, 1'b1, 32'h0, 1'b0, 1'b0},
        '{1'b0, 32'h00640001, 32'h00000000, 20'h00400, 1'b0, 1'b1, 32'h0, 1'b1, 1'b0},
        '{1'b0, 32'hff9bffff, 32'h00000000, 20'h00400, 1'b0, 1'b1, 32'h0, 1'b1, 1'b0},
        '{1'b0, 32'h00640000, 32'h7fffffff, 20'hfffff, 1'b1, 1'b0, 32'h0, 1'b0, 1'b0},
        '{1'b0, 32'h00000000, 32'h00000000, 20'h00001, 1'b1, 1'b0, 32'h0, 1'b0, 1'b0},
        '{1'b1, 32'h80000000, 32'hffffffff, 20'hfffff, 1'b1, 1'b1, 32'h0, 1'b0, 1'b0},
        '{1'b0, 32'h80000001, 32'h00000000, 20'h00100, 1'b1, 1'b0, 32'h0, 1'b0, 1'b0},
        '{1'b0, 32'h00000100, 32'h00050000, 20'h00800, 1'b1, 1'b0, 32'h0, 1'b0, 1'b0}
    };

    // ------------------------------------------------------------------
    // Fixed-point helpers of the predictor
    // ------------------------------------------------------------------
    function automatic longint clip32(input longint v);
        if (v > VMAX_L)
            return VMAX_L;
        if (v < VMIN_L)
            return VMIN_L;
        return v;
    endfunction

    function automatic longint abs_of(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint signed_mag(input longint m, input bit neg);
        if (neg)
            return (m > -VMIN_L) ? VMIN_L : -m;
        return (m > VMAX_L) ? VMAX_L : m;
    endfunction

    // Product shifted right, truncated toward zero, saturated
    function automatic longint scaled_product(input longint a, input longint b, input int sh);
        longint p;
        p = abs_of(a) * abs_of(b);
        return signed_mag(p >> sh, (a < 0) != (b < 0));
    endfunction

    // Rate of change: (num << TIME_FRACTION_BITS) / dt, saturated
    function automatic longint rate_of(input longint num, input longint dt);
        longint m;
        longint q;
        longint r;
        m = abs_of(num);
        q = m / dt;
        r = m % dt;
        if (q > (64'sd2147483648 >> pvs_pkg::TIME_FRACTION_BITS))
            return (num < 0) ? VMIN_L : VMAX_L;
        return signed_mag((q << pvs_pkg::TIME_FRACTION_BITS) +
                          ((r << pvs_pkg::TIME_FRACTION_BITS) / dt), num < 0);
    endfunction

    // Servo law for one accepted sample; advances the mirrored state
    function automatic servo_cmd_t servo_update(input logic op, input logic [31:0] pos_in,
                                                input logic [31:0] setp_in,
                                                input logic [19:0] dt_in, input logic drv);
        servo_cmd_t c;
        longint pos;
        longint setp;
        longint dt;
        longint err;
        longint deriv;
        longint sum;
        longint vel;
        longint sgn;
        pos  = longint'($signed(pos_in));
        setp = longint'($signed(setp_in));
        dt   = longint'(dt_in);
        c.velocity = '0;
        c.out_of_range = 1'b0;
        c.saturated = 1'b0;
        if (op)
        begin
            ref_pos  = pos;
            prev_pos = pos;
            homed    = 1'b1;
            return c;
        end
        c.out_of_range = homed && (pos < gain_regs[pvs_pkg::REG_LOWER_LIMIT] ||
                                   pos > gain_regs[pvs_pkg::REG_UPPER_LIMIT]);
        if (!sampling_on)
        begin
            dt = 0;
            ref_pos = pos;
            prev_pos = pos;
            sampling_on = 1'b1;
        end
        if (drv)
        begin
            ref_pos = clip32(ref_pos + scaled_product(dt, setp, pvs_pkg::TIME_FRACTION_BITS));
            err = clip32(ref_pos - pos);
            err_integral = clip32(err_integral +
                                  scaled_product(dt, err, pvs_pkg::TIME_FRACTION_BITS));
            deriv = 0;
            if (dt * 10000 >= (64'sd1 << pvs_pkg::TIME_FRACTION_BITS))
                deriv = rate_of(scaled_product(gain_regs[pvs_pkg::REG_DERIVATIVE_TIME],
                                               clip32(pos - prev_pos), pvs_pkg::FRAC_BITS),
                                dt);
            sum = clip32(err + scaled_product(gain_regs[pvs_pkg::REG_INTEGRAL_FACTOR],
                                              err_integral, pvs_pkg::FRAC_BITS) + deriv);
            vel = clip32(scaled_product(gain_regs[pvs_pkg::REG_SERVO_GAIN], sum,
                                        pvs_pkg::FRAC_BITS) +
                         scaled_product(gain_regs[pvs_pkg::REG_FEEDFORWARD_SCALE], setp,
                                        pvs_pkg::FRAC_BITS));
            // Friction follows the direction of motion, else the command sign
            if (prev_pos < pos)
                sgn = 1;
            else if (prev_pos > pos)
                sgn = -1;
            else
                sgn = (vel < 0) ? -1 : 1;
            vel = clip32(vel + sgn * gain_regs[pvs_pkg::REG_FRICTION_OFFSET]);
            if (vel < -gain_regs[pvs_pkg::REG_DRIVE_LIMIT])
            begin
                vel = -gain_regs[pvs_pkg::REG_DRIVE_LIMIT];
                c.saturated = 1'b1;
            end
            if (vel > gain_regs[pvs_pkg::REG_DRIVE_LIMIT])
            begin
                vel = gain_regs[pvs_pkg::REG_DRIVE_LIMIT];
                c.saturated = 1'b1;
            end
            c.velocity = vel[31:0];
        end
        prev_pos = pos;
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------
    task automatic write_reg(input pvs_pkg::cfg_reg_t idx, input logic [31:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        gain_regs[idx] = (idx == pvs_pkg::REG_DRIVE_LIMIT) ? longint'(data[30:0])
                                                           : longint'($signed(data));
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Offer one sample; valid stays high afterward until gap() lowers it
    task automatic send_sample(input logic op, input logic [31:0] pos, input logic [31:0] setp,
                               input logic [19:0] dt, input logic drv, input bit typed,
                               input servo_cmd_t typed_cmd);
        servo_cmd_t c;
        @(negedge clk);
        in_valid          = 1'b1;
        operation         = op;
        measured_position = pos;
        velocity_setpoint = setp;
        elapsed_time      = dt;
        axis_driven       = drv;
        do
            @(posedge clk);
        while (!in_ready);
        c = servo_update(op, pos, setp, dt, drv);
        pending_cmds.push_back(typed ? typed_cmd : c);
    endtask

    task automatic gap(input int cycles);
        if (cycles > 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (cycles - 1) @(negedge clk);
        end
    endtask

    function automatic int short_or_long_gap();
        int k;
        k = $urandom_range(0, 99);
        if (k < 45)
            return 0;
        if (k < 92)
            return $urandom_range(1, 4);
        return $urandom_range(20, 120);
    endfunction

    // Wait until every predicted command has come back, then let the block settle
    task automatic drain();
        gap(1);
        while (pending_cmds.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h80000000;
            1: return 32'h7fffffff;
            2: return 32'h0;
            3: return $urandom;
            default:
            begin
                logic [31:0] v;
                v = $urandom_range(0, 32'h40000);
                return $urandom_range(0, 1) ? -v : v;
            end
        endcase
    endfunction

    task automatic random_settings();
        logic [31:0] a;
        logic [31:0] b;
        write_reg(pvs_pkg::REG_SERVO_GAIN, pick_value());
        write_reg(pvs_pkg::REG_INTEGRAL_FACTOR, pick_value());
        write_reg(pvs_pkg::REG_FEEDFORWARD_SCALE, pick_value());
        write_reg(pvs_pkg::REG_DERIVATIVE_TIME, pick_value());
        write_reg(pvs_pkg::REG_FRICTION_OFFSET, pick_value());
        case ($urandom_range(0, 4))
            0: write_reg(pvs_pkg::REG_DRIVE_LIMIT, 32'h0);
            1: write_reg(pvs_pkg::REG_DRIVE_LIMIT, 32'h7fffffff);
            2: write_reg(pvs_pkg::REG_DRIVE_LIMIT, $urandom);
            default: write_reg(pvs_pkg::REG_DRIVE_LIMIT, $urandom_range(0, 32'h200000));
        endcase
        a = pick_value();
        b = pick_value();
        // Inverted limits are legal and occur here now and then
        write_reg(pvs_pkg::REG_LOWER_LIMIT, a);
        write_reg(pvs_pkg::REG_UPPER_LIMIT, b);
    endtask

    task automatic random_sample();
        logic [31:0] pos;
        logic [31:0] setp;
        logic [19:0] dt;
        servo_cmd_t  none;
        none = '{default: '0};
        case ($urandom_range(0, 19))
            0: pos = $urandom;
            1: pos = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            2: pos = walk_pos;
            default: pos = walk_pos + $signed($urandom_range(0, 32'h40000)) - 32'sh20000;
        endcase
        walk_pos = pos;
        case ($urandom_range(0, 7))
            0: setp = $urandom;
            1: setp = 32'h0;
            default: setp = $signed($urandom_range(0, 32'h80000)) - 32'sh40000;
        endcase
        case ($urandom_range(0, 9))
            0: dt = 20'h0;
            1: dt = 20'($urandom_range(100, 110));
            2: dt = 20'($urandom);
            3: dt = 20'hfffff;
            default: dt = 20'($urandom_range(1, 4000));
        endcase
        send_sample($urandom_range(0, 19) == 0, pos, setp, dt, $urandom_range(0, 9) != 0,
                    1'b0, none);
    endtask

    // ------------------------------------------------------------------
    // Clock, reset and stimulus
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        servo_cmd_t tc;
        rst_n = 1'b0;
        in_valid = 1'b0;
        operation = 1'b0;
        measured_position = '0;
        velocity_setpoint = '0;
        elapsed_time = '0;
        axis_driven = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = pvs_pkg::REG_SERVO_GAIN;
        cfg_data = '0;
        mismatches = 0;
        long_hold_req = 1'b0;
        rx_free_run = 1'b0;
        walk_pos = '0;
        foreach (gain_regs[i])
            gain_regs[i] = 0;
        gain_regs[pvs_pkg::REG_DRIVE_LIMIT] = VMAX_L;
        gain_regs[pvs_pkg::REG_LOWER_LIMIT] = VMIN_L;
        gain_regs[pvs_pkg::REG_UPPER_LIMIT] = VMAX_L;
        ref_pos = 0;
        err_integral = 0;
        prev_pos = 0;
        sampling_on = 1'b0;
        homed = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part under a readable setting
        write_reg(pvs_pkg::REG_SERVO_GAIN, 32'h00010000);
        write_reg(pvs_pkg::REG_INTEGRAL_FACTOR, 32'h00000800);
        write_reg(pvs_pkg::REG_FEEDFORWARD_SCALE, 32'h00008000);
        write_reg(pvs_pkg::REG_DERIVATIVE_TIME, 32'h00000100);
        write_reg(pvs_pkg::REG_FRICTION_OFFSET, 32'h00008000);
        write_reg(pvs_pkg::REG_DRIVE_LIMIT, 32'h00100000);
        write_reg(pvs_pkg::REG_LOWER_LIMIT, 32'hff9c0000);
        write_reg(pvs_pkg::REG_UPPER_LIMIT, 32'h00640000);
        foreach (sample_table[i])
        begin
            tc.velocity = sample_table[i].t_vel;
            tc.out_of_range = sample_table[i].t_oor;
            tc.saturated = sample_table[i].t_sat;
            send_sample(sample_table[i].op, sample_table[i].pos, sample_table[i].setp,
                        sample_table[i].dt, sample_table[i].drv, sample_table[i].typed, tc);
            gap(short_or_long_gap());
        end
        drain();

        // Random phases, each after a full drain and a new setting
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            random_settings();
            rx_free_run = (ph == 2);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (ph == 4 && n == 10)
                    long_hold_req = 1'b1;
                random_sample();
                if (ph != 4 && ph != 2)
                    gap(short_or_long_gap());
            end
            drain();
        end

        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Receiver: random stalls, one long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                out_ready = 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge clk);
                long_hold_req = 1'b0;
                out_ready = 1'b1;
            end
            else if (rx_free_run)
                out_ready = 1'b1;
            else if ($urandom_range(0, 49) == 0)
            begin
                out_ready = 1'b0;
                repeat ($urandom_range(20, 150)) @(negedge clk);
            end
            else
                out_ready = ($urandom_range(0, 3) != 0);
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        servo_cmd_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_cmds.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction: vel %h", drive_velocity);
            end
            else
            begin
                want = pending_cmds.pop_front();
                if (drive_velocity !== want.velocity ||
                    position_out_of_range !== want.out_of_range ||
                    drive_saturated !== want.saturated)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: vel exp %h got %h, oor exp %b got %b, sat exp %b got %b",
                                 want.velocity, drive_velocity, want.out_of_range,
                                 position_out_of_range, want.saturated, drive_saturated);
                end
            end
        end
    end

    // Watchdog on cycles without any transaction
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

endmodule
